// File: rtl/gpa_pkg.sv
`timescale 1ns / 1ps
// gpa_pkg: widths, opcodes and the degree function of the GF(2) polynomial unit.
// No dependencies.
package gpa_pkg;

    localparam int PolyWidth = 32;
    localparam int IdxWidth  = $clog2(PolyWidth);
    localparam int OpWidth   = 3;
    localparam int DegWidth  = 6;

    typedef logic [PolyWidth-1:0] poly_t;
    typedef logic [IdxWidth-1:0]  idx_t;
    typedef logic [OpWidth-1:0]   op_t;
    typedef logic signed [DegWidth-1:0] deg_t;

    localparam op_t OP_DEG = 3'd0;
    localparam op_t OP_MOD = 3'd1;
    localparam op_t OP_GCD = 3'd2;
    localparam op_t OP_MUL = 3'd3;
    localparam op_t OP_IRR = 3'd4;

    // index of the highest set bit; 0 for a zero word
    function automatic idx_t top_bit(input poly_t p);
        idx_t d;
        d = '0;
        for (int i = 0; i < PolyWidth; i++)
        begin
            if (p[i])
            begin
                d = idx_t'(i);
            end
        end
        return d;
    endfunction

endpackage

// File: rtl/gpa_if.sv
`timescale 1ns / 1ps
// gpa_req_if / gpa_rsp_if: valid/ready channels of the polynomial unit.
// Depends on gpa_pkg.
interface gpa_req_if;
    import gpa_pkg::*;
    logic  valid;
    logic  ready;
    op_t   opcode;
    poly_t operand_a;
    poly_t operand_b;
    poly_t poly_p;
    modport source (output valid, opcode, operand_a, operand_b, poly_p, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, poly_p, output ready);
endinterface

interface gpa_rsp_if;
    import gpa_pkg::*;
    logic  valid;
    logic  ready;
    poly_t result_poly;
    deg_t  poly_degree;
    logic  irreducible_flag;
    modport source (output valid, result_poly, poly_degree, irreducible_flag, input ready);
    modport sink   (input valid, result_poly, poly_degree, irreducible_flag, output ready);
endinterface

// File: rtl/gf2_poly_arithmetic_unit.sv
`timescale 1ns / 1ps
// gf2_poly_arithmetic_unit: top level, sequencer around the shared reduce unit.
// Depends on gpa_pkg, gpa_if, gpa_reduce_unit.
//
//  channel | dir | beat contents
//  req     | in  | opcode, operand_a, operand_b, poly_p
//  rsp     | out | result_poly, poly_degree, irreducible_flag
//
// One reduction or multiply step per cycle. Mod and gcd: about one
// reduction step per cleared bit. Multiply: two reductions plus one
// multiply step per bit of the reduced a. Irreducibility: deg(p)/2 rounds
// of multiply plus gcd. req.ready is high only while idle; a finished
// result waits in the output register while the next beat is taken.
// Reset clears control only.
module gf2_poly_arithmetic_unit (
    input  logic         clk,
    input  logic         rst_n,
    gpa_req_if.sink      req,
    gpa_rsp_if.source    rsp
);
    import gpa_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MODA = 6'b000010,
        ST_MODB = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_GCD  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    poly_t  x_reg, x_next, y_reg, y_next, r_reg, r_next, p_reg, p_next, s_reg, s_next;
    idx_t   dp_reg, dp_next, cnt_reg, cnt_next;
    poly_t  res_poly_reg, res_poly_next;
    deg_t   res_deg_reg, res_deg_next;
    logic   res_flag_reg, res_flag_next;
    logic   out_valid_reg, out_valid_next;
    poly_t  out_poly_reg, out_poly_next;
    deg_t   out_deg_reg, out_deg_next;
    logic   out_flag_reg, out_flag_next;

    poly_t  u_dividend, u_divisor, u_step;
    logic   u_done;
    poly_t  yy;
    idx_t   rounds;
    poly_t  xf;

    gpa_reduce_unit u_reduce (
        .dividend (u_dividend),
        .divisor  (u_divisor),
        .step_out (u_step),
        .done     (u_done)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_MODB:
            begin
                u_dividend = y_reg;
                u_divisor  = p_reg;
            end
            ST_GCD:
            begin
                u_dividend = x_reg;
                u_divisor  = y_reg;
            end
            default:
            begin
                u_dividend = x_reg;
                u_divisor  = p_reg;
            end
        endcase
    end

    assign req.ready            = (state_reg == ST_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.result_poly      = out_poly_reg;
    assign rsp.poly_degree      = out_deg_reg;
    assign rsp.irreducible_flag = out_flag_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        dp_next        = dp_reg;
        cnt_next       = cnt_reg;
        res_poly_next  = res_poly_reg;
        res_deg_next   = res_deg_reg;
        res_flag_next  = res_flag_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_poly_next  = out_poly_reg;
        out_deg_next   = out_deg_reg;
        out_flag_next  = out_flag_reg;
        rounds         = top_bit(req.poly_p) >> 1;
        xf             = (p_reg == '0) ? '0 : x_reg;
        yy             = y_reg << 1;
        if (yy[dp_reg])
        begin
            yy = yy ^ p_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = req.opcode;
                    x_next        = req.operand_a;
                    y_next        = req.operand_b;
                    p_next        = req.poly_p;
                    dp_next       = top_bit(req.poly_p);
                    r_next        = '0;
                    s_next        = poly_t'(2);
                    cnt_next      = rounds;
                    res_poly_next = '0;
                    res_deg_next  = '0;
                    res_flag_next = 1'b0;
                    state_next    = ST_DONE;
                    case (req.opcode)
                        OP_DEG:
                        begin
                            res_deg_next = (req.poly_p == '0) ? '1
                                         : deg_t'(top_bit(req.poly_p));
                        end
                        OP_MOD, OP_MUL:
                        begin
                            state_next = ST_MODA;
                        end
                        OP_GCD:
                        begin
                            state_next = ST_GCD;
                        end
                        OP_IRR:
                        begin
                            if (req.poly_p != '0)
                            begin
                                if (rounds == '0)
                                begin
                                    res_flag_next = 1'b1;
                                end
                                else
                                begin
                                    x_next     = poly_t'(2);
                                    y_next     = poly_t'(2);
                                    state_next = ST_MODA;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MODA:
            begin
                if (p_reg == '0 || u_done)
                begin
                    if (op_reg == OP_MOD)
                    begin
                        res_poly_next = xf;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        x_next     = xf;
                        state_next = ST_MODB;
                    end
                end
                else
                begin
                    x_next = u_step;
                end
            end
            ST_MODB:
            begin
                if (p_reg == '0 || u_done)
                begin
                    if (p_reg == '0)
                    begin
                        y_next = '0;
                    end
                    r_next     = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    y_next = u_step;
                end
            end
            ST_MUL:
            begin
                if (x_reg == '0)
                begin
                    if (op_reg == OP_MUL)
                    begin
                        res_poly_next = r_reg;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        s_next     = r_reg;
                        x_next     = r_reg ^ poly_t'(2);
                        y_next     = p_reg;
                        state_next = ST_GCD;
                    end
                end
                else
                begin
                    if (x_reg[0])
                    begin
                        r_next = r_reg ^ y_reg;
                    end
                    x_next = x_reg >> 1;
                    y_next = yy;
                end
            end
            ST_GCD:
            begin
                if (y_reg == '0)
                begin
                    if (op_reg == OP_GCD)
                    begin
                        res_poly_next = x_reg;
                        state_next    = ST_DONE;
                    end
                    else if (x_reg != poly_t'(1))
                    begin
                        res_flag_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else if (cnt_reg == idx_t'(1))
                    begin
                        res_flag_next = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - idx_t'(1);
                        x_next     = s_reg;
                        y_next     = s_reg;
                        state_next = ST_MODA;
                    end
                end
                else if (u_done)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                begin
                    x_next = u_step;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_poly_next  = res_poly_reg;
                    out_deg_next   = res_deg_reg;
                    out_flag_next  = res_flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        r_reg        <= r_next;
        p_reg        <= p_next;
        s_reg        <= s_next;
        dp_reg       <= dp_next;
        cnt_reg      <= cnt_next;
        res_poly_reg <= res_poly_next;
        res_deg_reg  <= res_deg_next;
        res_flag_reg <= res_flag_next;
        out_poly_reg <= out_poly_next;
        out_deg_reg  <= out_deg_next;
        out_flag_reg <= out_flag_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && p_reg != '0) |-> ((y_reg >> dp_reg) == '0))
        else $error("multiplicand not reduced");

    a_irr_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD && op_reg == OP_IRR) |-> (cnt_reg != '0))
        else $error("irreducibility round count empty");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not loaded");
endmodule

// File: rtl/gpa_reduce_unit.sv
`timescale 1ns / 1ps
// gpa_reduce_unit: one shift-xor reduction step, shared by mod and gcd.
// Depends on gpa_pkg.
module gpa_reduce_unit (
    input  gpa_pkg::poly_t dividend,
    input  gpa_pkg::poly_t divisor,
    output gpa_pkg::poly_t step_out,
    output logic           done
);
    import gpa_pkg::*;

    idx_t d_hi;
    idx_t v_hi;
    idx_t sh;

    always_comb
    begin
        d_hi     = top_bit(dividend);
        v_hi     = top_bit(divisor);
        sh       = d_hi - v_hi;
        done     = (dividend == '0) || (divisor == '0) || (d_hi < v_hi);
        step_out = dividend ^ (divisor << sh);
    end
endmodule
